### rtl/hpack_huffman_encoder_macros.svh
// assertion helpers
`ifndef HPACK_HUFFMAN_ENCODER_MACROS_SVH
`define HPACK_HUFFMAN_ENCODER_MACROS_SVH

`define HPK_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define HPK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hpack_pkg.sv
package hpack_pkg;

    localparam int unsigned SYM_W   = 8;
    localparam int unsigned CODE_W  = 30;
    localparam int unsigned LEN_W   = 5;
    localparam int unsigned ACC_W   = 37;
    localparam int unsigned TOT_W   = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic have_byte;
        logic have_pad;
    } t_status;

    function automatic logic [LEN_W-1:0] f_len(input logic [SYM_W-1:0] s);
        logic [7:0] t [256];
        t = '{
         13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
         28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
         6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
         5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
         13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
         7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
         15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
         6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
         20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
         24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
         22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
         21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
         26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
         19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
         20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
         26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26};
        return t[s][LEN_W-1:0];
    endfunction

    function automatic logic [CODE_W-1:0] f_code(input logic [SYM_W-1:0] s);
        logic [31:0] t [256];
        t = '{
 32'h1ff8,32'h7fffd8,32'hfffffe2,32'hfffffe3,32'hfffffe4,32'hfffffe5,32'hfffffe6,32'hfffffe7,
 32'hfffffe8,32'hffffea,32'h3ffffffc,32'hfffffe9,32'hfffffea,32'h3ffffffd,32'hfffffeb,
 32'hfffffec,
 32'hfffffed,32'hfffffee,32'hfffffef,32'hffffff0,32'hffffff1,32'hffffff2,32'h3ffffffe,
 32'hffffff3,
 32'hffffff4,32'hffffff5,32'hffffff6,32'hffffff7,32'hffffff8,32'hffffff9,32'hffffffa,
 32'hffffffb,
 32'h14,32'h3f8,32'h3f9,32'hffa,32'h1ff9,32'h15,32'hf8,32'h7fa,
 32'h3fa,32'h3fb,32'hf9,32'h7fb,32'hfa,32'h16,32'h17,32'h18,
 32'h0,32'h1,32'h2,32'h19,32'h1a,32'h1b,32'h1c,32'h1d,
 32'h1e,32'h1f,32'h5c,32'hfb,32'h7ffc,32'h20,32'hffb,32'h3fc,
 32'h1ffa,32'h21,32'h5d,32'h5e,32'h5f,32'h60,32'h61,32'h62,
 32'h63,32'h64,32'h65,32'h66,32'h67,32'h68,32'h69,32'h6a,
 32'h6b,32'h6c,32'h6d,32'h6e,32'h6f,32'h70,32'h71,32'h72,
 32'hfc,32'h73,32'hfd,32'h1ffb,32'h7fff0,32'h1ffc,32'h3ffc,32'h22,
 32'h7ffd,32'h3,32'h23,32'h4,32'h24,32'h5,32'h25,32'h26,
 32'h27,32'h6,32'h74,32'h75,32'h28,32'h29,32'h2a,32'h7,
 32'h2b,32'h76,32'h2c,32'h8,32'h9,32'h2d,32'h77,32'h78,
 32'h79,32'h7a,32'h7b,32'h7ffe,32'h7fc,32'h3ffd,32'h1ffd,32'hffffffc,
 32'hfffe6,32'h3fffd2,32'hfffe7,32'hfffe8,32'h3fffd3,32'h3fffd4,32'h3fffd5,32'h7fffd9,
 32'h3fffd6,32'h7fffda,32'h7fffdb,32'h7fffdc,32'h7fffdd,32'h7fffde,32'hffffeb,32'h7fffdf,
 32'hffffec,32'hffffed,32'h3fffd7,32'h7fffe0,32'hffffee,32'h7fffe1,32'h7fffe2,32'h7fffe3,
 32'h7fffe4,32'h1fffdc,32'h3fffd8,32'h7fffe5,32'h3fffd9,32'h7fffe6,32'h7fffe7,32'hffffef,
 32'h3fffda,32'h1fffdd,32'hfffe9,32'h3fffdb,32'h3fffdc,32'h7fffe8,32'h7fffe9,32'h1fffde,
 32'h7fffea,32'h3fffdd,32'h3fffde,32'hfffff0,32'h1fffdf,32'h3fffdf,32'h7fffeb,32'h7fffec,
 32'h1fffe0,32'h1fffe1,32'h3fffe0,32'h1fffe2,32'h7fffed,32'h3fffe1,32'h7fffee,32'h7fffef,
 32'hfffea,32'h3fffe2,32'h3fffe3,32'h3fffe4,32'h7ffff0,32'h3fffe5,32'h3fffe6,32'h7ffff1,
 32'h3ffffe0,32'h3ffffe1,32'hfffeb,32'h7fff1,32'h3fffe7,32'h7ffff2,32'h3fffe8,32'h1ffffec,
 32'h3ffffe2,32'h3ffffe3,32'h3ffffe4,32'h7ffffde,32'h7ffffdf,32'h3ffffe5,32'hfffff1,
 32'h1ffffed,
 32'h7fff2,32'h1fffe3,32'h3ffffe6,32'h7ffffe0,32'h7ffffe1,32'h3ffffe7,32'h7ffffe2,
 32'hfffff2,
 32'h1fffe4,32'h1fffe5,32'h3ffffe8,32'h3ffffe9,32'hffffffd,32'h7ffffe3,32'h7ffffe4,
 32'h7ffffe5,
 32'hfffec,32'hfffff3,32'hfffed,32'h1fffe6,32'h3fffe9,32'h1fffe7,32'h1fffe8,32'h7ffff3,
 32'h3fffea,32'h3fffeb,32'h1ffffee,32'h1ffffef,32'hfffff4,32'hfffff5,32'h3ffffea,
 32'h7ffff4,
 32'h3ffffeb,32'h7ffffe6,32'h3ffffec,32'h3ffffed,32'h7ffffe7,32'h7ffffe8,32'h7ffffe9,
 32'h7ffffea,
 32'h7ffffeb,32'hffffffe,32'h7ffffec,32'h7ffffed,32'h7ffffee,32'h7ffffef,32'h7fffff0,
 32'h3ffffee};
        return t[s][CODE_W-1:0];
    endfunction

endpackage

### rtl/hpack_ctrl.sv
`include "hpack_huffman_encoder_macros.svh"

module hpack_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  hpack_pkg::t_status i_status,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output hpack_pkg::t_cmd   o_cmd
);
    import hpack_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.have_byte || i_status.have_pad) begin
                    o_out_valid = 1'b1;
                    if (i_out_ready) begin
                        o_cmd.shift = 1'b1;
                    end
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `HPK_ASSERT_IMPL(a_no_out_idle, i_clk, i_rst_n, r_state == ST_IDLE, !o_out_valid,
        "output valid while idle")
    `HPK_ASSERT_NEXT(a_load_to_emit, i_clk, i_rst_n, o_cmd.load, r_state == ST_EMIT,
        "load did not enter emit")
    `HPK_ASSERT_IMPL(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd),
        "conflicting commands")
endmodule

### rtl/hpack_dp.sv
module hpack_dp (
    input  logic                 i_clk,
    input  logic [7:0]           i_symbol,
    input  logic                 i_eos,
    input  logic                 i_rst_n,
    input  hpack_pkg::t_cmd      i_cmd,
    output hpack_pkg::t_status   o_status,
    output logic [7:0]           o_byte,
    output logic                 o_last
);
    import hpack_pkg::*;

    logic [ACC_W-1:0]  r_acc;
    logic [TOT_W-1:0]  r_total;
    logic              r_eos;
    logic [6:0]        r_pend;
    logic [2:0]        r_cnt;
    logic [LEN_W-1:0]  w_len;
    logic [ACC_W-1:0]  w_new;
    logic [ACC_W+7:0]  w_sh;
    logic [TOT_W-1:0]  w_rem;
    logic [7:0]        w_full;
    logic [7:0]        w_pad;

    assign w_len = f_len(i_symbol);
    assign w_new = (ACC_W'(r_pend & 7'((8'd1 << r_cnt) - 8'd1)) << w_len)
                 | ACC_W'(f_code(i_symbol));
    assign w_rem = r_total - TOT_W'(8);
    assign w_sh  = {r_acc, 8'd0} >> r_total;
    assign w_full = w_sh[7:0];
    // partial byte left aligned, ones below
    assign w_pad = 8'((({r_acc[6:0], 8'd0} >> r_total[2:0]) | (15'h00ff >> r_total[2:0])));

    assign o_status.have_byte = r_total >= TOT_W'(8);
    assign o_status.have_pad  = r_eos && (r_total != '0);
    assign o_byte = o_status.have_byte ? w_full : w_pad;
    assign o_last = r_eos && (o_status.have_byte ? (w_rem == '0) : 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_eos   <= 1'b0;
            r_pend  <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.load) begin
            r_acc   <= w_new;
            r_total <= TOT_W'(r_cnt) + TOT_W'(w_len);
            r_eos   <= i_eos;
        end else if (i_cmd.shift) begin
            r_total <= o_status.have_byte ? w_rem : '0;
        end else if (i_cmd.finish) begin
            r_pend  <= r_eos ? 7'd0 : r_acc[6:0];
            r_cnt   <= r_eos ? 3'd0 : r_total[2:0];
        end
    end
endmodule

### rtl/hpack_huffman_encoder.sv
// HPACK static Huffman encoder: each input octet is replaced by its 5 to 30 bit
// code, packed MSB first into output bytes; up to 7 bits carry over to the next
// octet. tlast on an input flushes the string, padding the last byte with ones
// and marking the final output byte with tlast. Each octet passes through a load
// step, one shift step per output byte (0 to 5 bytes, as the single output shifter is
// byte wide) and a closing step; the next octet is taken only after the closing step.
module hpack_huffman_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // symbol[7:0]
    input  logic       s_axis_tlast,   // end_of_string
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte[7:0]
    output logic       m_axis_tlast    // out_last
);
    import hpack_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    hpack_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    hpack_dp u_dp (
        .i_clk    (i_clk),
        .i_symbol (s_axis_tdata),
        .i_eos    (s_axis_tlast),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_byte   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );
endmodule
